// ===== rtl/mbrp_pkg.sv =====
// Shared types, layout offsets and codes for the partition table parser.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package mbrp_pkg;

    // Table geometry and sector layout.
    localparam int NUM_SLOTS = 4;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    localparam logic [8:0]  TABLE_BASE      = 9'd446;
    localparam logic [8:0]  SIG_LOW_OFFSET  = 9'd510;
    localparam logic [8:0]  SIG_HIGH_OFFSET = 9'd511;
    localparam logic [15:0] BOOT_SIGNATURE  = 16'hAA55;
    localparam logic [7:0]  ACTIVE          = 8'h80;

    // Reset values of the unix type code registers.
    localparam logic [7:0]  SUNIXOS  = 8'd130;
    localparam logic [7:0]  SUNIXOS2 = 8'd191;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISK_BLOCKS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNIX_PRIMARY  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNIX_SECONDARY = 2'd2;

    // Input beat: one sector byte.
    typedef struct packed {
        logic [7:0] sector_byte;
        logic       frame_start;
    } in_beat_t;

    // Output beat: one slot result.
    typedef struct packed {
        logic [2:0]  slot_number;
        logic        entry_valid;
        logic [7:0]  system_type;
        logic [30:0] start_block;
        logic [30:0] block_count;
        logic        table_present;
        logic [2:0]  unix_slot;
        logic        label_read_needed;
        logic        last_of_run;
    } out_beat_t;

    // One stored partition entry.
    typedef struct packed {
        logic [7:0]  boot;
        logic [7:0]  sys_type;
        logic [31:0] start;
        logic [31:0] count;
    } entry_t;

    // Status of the byte currently offered to the intake.
    typedef struct packed {
        logic last_byte;
        logic present;
    } intake_t;

    // Verdict of the slot check unit.
    typedef struct packed {
        logic ok;
        logic is_unix;
        logic active;
    } check_t;

endpackage

// ===== rtl/mbr_partition_table_parser_unit.sv =====
// Partition table parser top level: byte intake, slot sequencer, result register.
// The signature byte starts a run of four slot results, each checked, then presented
// (ST_EVAL, then ST_SEND), with a result held while the output side stalls.
// Throughput: one byte per cycle while the sequencer is idle; no bytes are taken during
// the four passes through the single slot check unit. Depends on mbrp_pkg, mbrp_*.
// Reset (rst_n, async, low) clears offset, signature byte, sequencer and config registers.
module mbr_partition_table_parser_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mbrp_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mbrp_pkg::out_beat_t                 out_data,
    input  logic                                cfg_we,
    input  logic [mbrp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mbrp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EVAL = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    localparam logic [mbrp_pkg::SLOT_W-1:0] LAST_SLOT =
        mbrp_pkg::SLOT_W'(mbrp_pkg::NUM_SLOTS - 1);

    state_t state_reg, state_next;

    logic [mbrp_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [2:0]                  uslot_reg, uslot_next;
    logic                        present_reg, present_next;
    mbrp_pkg::out_beat_t         out_reg, out_next;

    logic [31:0] disk_blocks_reg;
    logic [7:0]  unix_primary_reg;
    logic [7:0]  unix_secondary_reg;

    logic                 in_accept;
    logic                 out_accept;
    mbrp_pkg::entry_t     rd_entry;
    mbrp_pkg::intake_t    intake;
    mbrp_pkg::check_t     verdict;
    logic [2:0]           slot_number;
    logic                 is_last;
    logic [2:0]           uslot_upd;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (state_reg == ST_SEND);
    assign out_accept = out_valid && !out_stall;
    assign out_data   = out_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_blocks_reg    <= 32'd0;
            unix_primary_reg   <= mbrp_pkg::SUNIXOS;
            unix_secondary_reg <= mbrp_pkg::SUNIXOS2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbrp_pkg::CFG_DISK_BLOCKS:    disk_blocks_reg    <= cfg_wdata;
                mbrp_pkg::CFG_UNIX_PRIMARY:   unix_primary_reg   <= cfg_wdata[7:0];
                mbrp_pkg::CFG_UNIX_SECONDARY: unix_secondary_reg <= cfg_wdata[7:0];
                default:                      ;
            endcase
        end
    end

    mbrp_entry_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_accept),
        .in_data  (in_data),
        .rd_idx   (slot_reg),
        .rd_entry (rd_entry),
        .status   (intake)
    );

    mbrp_slot_check u_check (
        .entry          (rd_entry),
        .present        (present_reg),
        .disk_blocks    (disk_blocks_reg),
        .unix_primary   (unix_primary_reg),
        .unix_secondary (unix_secondary_reg),
        .verdict        (verdict)
    );

    // Unix slot choice: first valid unix entry, replaced by a later active one.
    assign slot_number = {1'b0, slot_reg} + 3'd1;
    assign is_last     = (slot_reg == LAST_SLOT);
    assign uslot_upd   = (verdict.ok && verdict.is_unix &&
                          (uslot_reg == 3'd0 || verdict.active)) ? slot_number : uslot_reg;

    // Sequencer: wait for the signature byte, then check and present each slot.
    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        uslot_next   = uslot_reg;
        present_next = present_reg;
        out_next     = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && intake.last_byte)
                begin
                    present_next = intake.present;
                    slot_next    = '0;
                    uslot_next   = 3'd0;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                uslot_next                 = uslot_upd;
                out_next.slot_number       = slot_number;
                out_next.entry_valid       = verdict.ok;
                out_next.system_type       = verdict.ok ? rd_entry.sys_type : 8'd0;
                out_next.start_block       = verdict.ok ? rd_entry.start[30:0] : 31'd0;
                out_next.block_count       = verdict.ok ? rd_entry.count[30:0] : 31'd0;
                out_next.table_present     = present_reg;
                out_next.unix_slot         = is_last ? uslot_upd : 3'd0;
                out_next.label_read_needed = is_last && (!present_reg || uslot_upd != 3'd0);
                out_next.last_of_run       = is_last;
                state_next                 = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_accept)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_EVAL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            uslot_reg   <= 3'd0;
            present_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            uslot_reg   <= uslot_next;
            present_reg <= present_next;
        end
    end

    // Result register holds its beat while the output side stalls.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    // No byte is taken while a result beat is pending.
    a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    // The last-of-run flag appears only on the fourth slot.
    a_last_on_fourth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.last_of_run) |-> (out_data.slot_number == 3'd4))
        else $error("last_of_run on a slot other than the fourth");

    // After the last beat of a run the block is ready for bytes again.
    a_idle_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && out_data.last_of_run) |=> !in_stall)
        else $error("block did not return to idle after a run");

    // An invalid entry reports zero type, start and count.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.entry_valid) |->
        (out_data.system_type == 8'd0 && out_data.start_block == 31'd0 &&
         out_data.block_count == 31'd0))
        else $error("invalid entry carries nonzero fields");

    // The signature byte starts a run of results; slot one is presented after a pass through ST_EVAL.
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && intake.last_byte) |=> ##1 (out_valid && out_data.slot_number == 3'd1))
        else $error("run did not start after the signature byte");
`endif

endmodule

// ===== rtl/mbrp_entry_store.sv =====
// Byte intake: offset counter, partition entry registers and signature byte.
// Depends on mbrp_pkg.
module mbrp_entry_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  mbrp_pkg::in_beat_t              in_data,
    input  logic [mbrp_pkg::SLOT_W-1:0]     rd_idx,
    output mbrp_pkg::entry_t                rd_entry,
    output mbrp_pkg::intake_t               status
);

    logic [8:0] offset_reg;
    logic [8:0] offset_next;
    logic [7:0] sig_low_reg;
    logic [7:0] sig_low_next;

    logic [7:0]  boot_reg  [mbrp_pkg::NUM_SLOTS];
    logic [7:0]  type_reg  [mbrp_pkg::NUM_SLOTS];
    logic [31:0] start_reg [mbrp_pkg::NUM_SLOTS];
    logic [31:0] count_reg [mbrp_pkg::NUM_SLOTS];

    logic [8:0]                  cur_off;
    logic [8:0]                  rel;
    logic                        in_table;
    logic [3:0]                  lane_k;
    logic [mbrp_pkg::SLOT_W-1:0] wr_idx;
    logic [4:0]                  bit_pos;

    // A frame start forces this byte to offset zero.
    assign cur_off  = in_data.frame_start ? 9'd0 : offset_reg;
    assign rel      = cur_off - mbrp_pkg::TABLE_BASE;
    assign in_table = (cur_off >= mbrp_pkg::TABLE_BASE) &&
                      (cur_off < mbrp_pkg::SIG_LOW_OFFSET);
    assign lane_k   = rel[3:0];
    assign wr_idx   = rel[5:4];
    assign bit_pos  = {lane_k[1:0], 3'b000};

    // The offset wraps after the signature's high byte.
    assign offset_next  = wr_en ? (cur_off + 9'd1) : offset_reg;
    assign sig_low_next = (wr_en && cur_off == mbrp_pkg::SIG_LOW_OFFSET) ?
                          in_data.sector_byte : sig_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= 9'd0;
            sig_low_reg <= 8'd0;
        end
        else
        begin
            offset_reg  <= offset_next;
            sig_low_reg <= sig_low_next;
        end
    end

    // Entry fields are captured byte by byte; boot, type, start and count lanes.
    always_ff @(posedge clk)
    begin
        if (wr_en && in_table)
        begin
            case (lane_k) inside
                4'd0:           boot_reg[wr_idx] <= in_data.sector_byte;
                4'd4:           type_reg[wr_idx] <= in_data.sector_byte;
                [4'd8:4'd11]:   start_reg[wr_idx][bit_pos +: 8] <= in_data.sector_byte;
                [4'd12:4'd15]:  count_reg[wr_idx][bit_pos +: 8] <= in_data.sector_byte;
                default:        ;
            endcase
        end
    end

    // Read port for the slot check sequencer.
    always_comb
    begin
        rd_entry.boot     = boot_reg[rd_idx];
        rd_entry.sys_type = type_reg[rd_idx];
        rd_entry.start    = start_reg[rd_idx];
        rd_entry.count    = count_reg[rd_idx];
    end

    // The signature is judged on the byte at the last offset.
    assign status.last_byte = (cur_off == mbrp_pkg::SIG_HIGH_OFFSET);
    assign status.present   = ({in_data.sector_byte, sig_low_reg} ==
                               mbrp_pkg::BOOT_SIGNATURE);

endmodule

// ===== rtl/mbrp_slot_check.sv =====
// Shared slot check unit: sanity checks and the 33-bit extent compare.
// Depends on mbrp_pkg; used once per slot by the top-level sequencer.
module mbrp_slot_check (
    input  mbrp_pkg::entry_t  entry,
    input  logic              present,
    input  logic [31:0]       disk_blocks,
    input  logic [7:0]        unix_primary,
    input  logic [7:0]        unix_secondary,
    output mbrp_pkg::check_t  verdict
);

    logic [32:0] extent_end;
    logic        fits;

    // Exact end of the partition, compared against the disk size.
    assign extent_end = {1'b0, entry.start} + {1'b0, entry.count};
    assign fits       = (extent_end <= {1'b0, disk_blocks});

    assign verdict.ok = present &&
                        (entry.sys_type != 8'd0) &&
                        !entry.start[31] &&
                        (entry.count != 32'd0) &&
                        !entry.count[31] &&
                        fits;

    assign verdict.is_unix = (entry.sys_type == unix_primary) ||
                             (entry.sys_type == unix_secondary);
    assign verdict.active  = (entry.boot == mbrp_pkg::ACTIVE);

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the partition table parser: streams whole sectors,
// predicts the four slot results of each one and compares every result beat.
// Depends on mbrp_pkg and mbr_partition_table_parser_unit from rtl/.
module testbench;

    localparam int unsigned SETTLE_CYCLES    = 16;
    localparam int unsigned HOLD_CYCLES      = 3000;
    localparam int unsigned WATCHDOG_LIMIT   = 20000;
    localparam int unsigned FRAMES_PER_GROUP = 6;

    // Four primary entries of one sector, slot 1 leftmost.
    typedef mbrp_pkg::entry_t [0:3] part_table_t;

    // One directed sector: optional register settings, table content, framing
    // and, where it reads off plainly, the expected slot results.
    typedef struct packed {
        logic        reconfig;
        logic [31:0] disk;
        logic [7:0]  code_a;
        logic [7:0]  code_b;
        part_table_t ents;
        logic [15:0] sig;
        logic        wrap;
        logic [8:0]  cut;
        logic        typed;
        logic [3:0]  want_valid;
        logic        want_present;
        logic [2:0]  want_unix;
        logic        want_label;
    } sector_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    mbrp_pkg::in_beat_t               in_data;
    logic                             out_valid;
    logic                             out_stall;
    mbrp_pkg::out_beat_t              out_data;
    logic                             cfg_we;
    logic [mbrp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mbrp_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    // Predictor state: register copies and the sector being assembled.
    logic [31:0]       cfg_disk_blocks = 32'd0;
    logic [7:0]        cfg_unix_a      = mbrp_pkg::SUNIXOS;
    logic [7:0]        cfg_unix_b      = mbrp_pkg::SUNIXOS2;
    logic [8:0]        pred_offset     = 9'd0;
    logic [7:0]        pred_sig_low    = 8'd0;
    mbrp_pkg::entry_t  pred_entries [mbrp_pkg::NUM_SLOTS];

    mbrp_pkg::out_beat_t slot_results_due [$];
    mbrp_pkg::out_beat_t typed_beats [mbrp_pkg::NUM_SLOTS];
    logic                typed_pending   = 1'b0;

    sector_row_t sector_rows [11];
    bit          calm_in         = 1'b0;
    bit          hold_off_request = 1'b0;
    int unsigned bytes_taken     = 0;
    int unsigned frames_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned error_count     = 0;

    mbr_partition_table_parser_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic mbrp_pkg::entry_t part_entry(logic [7:0] boot, logic [7:0] kind,
                                                    logic [31:0] start, logic [31:0] count);
        mbrp_pkg::entry_t e;
        e.boot     = boot;
        e.sys_type = kind;
        e.start    = start;
        e.count    = count;
        return e;
    endfunction

    // Track one accepted byte; on the second signature byte queue the four slot results.
    function automatic void absorb_byte(mbrp_pkg::in_beat_t beat);
        logic [8:0]          off;
        logic [8:0]          rel;
        logic [1:0]          slot;
        logic [3:0]          lane;
        logic                present;
        logic                ok;
        logic [2:0]          chosen;
        mbrp_pkg::out_beat_t res [mbrp_pkg::NUM_SLOTS];
        off = beat.frame_start ? 9'd0 : pred_offset;
        pred_offset = off + 9'd1;
        rel  = off - mbrp_pkg::TABLE_BASE;
        slot = rel[5:4];
        lane = rel[3:0];
        if (off >= mbrp_pkg::TABLE_BASE && off < mbrp_pkg::SIG_LOW_OFFSET)
        begin
            if (lane == 4'd0)
                pred_entries[slot].boot = beat.sector_byte;
            else if (lane == 4'd4)
                pred_entries[slot].sys_type = beat.sector_byte;
            else if (lane[3:2] == 2'b10)
                pred_entries[slot].start[{lane[1:0], 3'b000} +: 8] = beat.sector_byte;
            else if (lane[3:2] == 2'b11)
                pred_entries[slot].count[{lane[1:0], 3'b000} +: 8] = beat.sector_byte;
        end
        else if (off == mbrp_pkg::SIG_LOW_OFFSET)
        begin
            pred_sig_low = beat.sector_byte;
        end
        else if (off == mbrp_pkg::SIG_HIGH_OFFSET)
        begin
            present = ({beat.sector_byte, pred_sig_low} == mbrp_pkg::BOOT_SIGNATURE);
            chosen  = 3'd0;
            for (int i = 0; i < mbrp_pkg::NUM_SLOTS; i++)
            begin
                ok = present && pred_entries[i].sys_type != 8'd0
                     && !pred_entries[i].start[31]
                     && pred_entries[i].count != 32'd0 && !pred_entries[i].count[31]
                     && ({1'b0, pred_entries[i].start} + {1'b0, pred_entries[i].count}
                         <= {1'b0, cfg_disk_blocks});
                // A later active unix entry takes over from the first one found.
                if (ok && (pred_entries[i].sys_type == cfg_unix_a
                           || pred_entries[i].sys_type == cfg_unix_b)
                       && (chosen == 3'd0 || pred_entries[i].boot == mbrp_pkg::ACTIVE))
                    chosen = 3'(i + 1);
                res[i] = '0;
                res[i].slot_number   = 3'(i + 1);
                res[i].entry_valid   = ok;
                res[i].table_present = present;
                if (ok)
                begin
                    res[i].system_type = pred_entries[i].sys_type;
                    res[i].start_block = pred_entries[i].start[30:0];
                    res[i].block_count = pred_entries[i].count[30:0];
                end
            end
            res[mbrp_pkg::NUM_SLOTS-1].unix_slot         = chosen;
            res[mbrp_pkg::NUM_SLOTS-1].label_read_needed = !present || chosen != 3'd0;
            res[mbrp_pkg::NUM_SLOTS-1].last_of_run       = 1'b1;
            for (int i = 0; i < mbrp_pkg::NUM_SLOTS; i++)
                slot_results_due.push_back(typed_pending ? typed_beats[i] : res[i]);
            typed_pending = 1'b0;
        end
    endfunction

    // Sender gap length: mostly none (always none when calm), sometimes short, rarely a long pause.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_in || r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random entry biased toward the current unix codes and the disk boundary.
    function automatic mbrp_pkg::entry_t random_entry();
        mbrp_pkg::entry_t e;
        logic [32:0]      room;
        case ($urandom_range(0, 3))
            0:       e.boot = mbrp_pkg::ACTIVE;
            1:       e.boot = 8'h00;
            default: e.boot = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       e.sys_type = 8'h00;
            1, 3:    e.sys_type = cfg_unix_a;
            2:       e.sys_type = cfg_unix_b;
            default: e.sys_type = 8'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:
            begin
                e.start = $urandom;
                e.count = $urandom;
            end
            1:
            begin
                e.start = $urandom_range(0, 64);
                e.count = 32'd0;
            end
            default:
            begin
                e.start = $urandom_range(0, cfg_disk_blocks);
                room    = {1'b0, cfg_disk_blocks} - {1'b0, e.start};
                case ($urandom_range(0, 3))
                    0:       e.count = 32'(room);
                    1:       e.count = 32'(room + 33'd1);
                    default: e.count = $urandom_range(1, 32'(room));
                endcase
            end
        endcase
        return e;
    endfunction

    // Offer one input beat after a random gap and hold it until it is taken.
    task automatic send_beat(logic [7:0] value, logic mark);
        int unsigned        gap;
        mbrp_pkg::in_beat_t beat;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.sector_byte = value;
        beat.frame_start = mark;
        in_data  <= beat;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb_byte(beat);
        bytes_taken++;
    endtask

    // Send a whole sector, optionally after a junk prefix that is cut short by a restart.
    task automatic send_sector(part_table_t ents, logic [15:0] sig, logic mark,
                               int unsigned cut);
        int unsigned n;
        int unsigned off;
        logic [8:0]  rel;
        logic [7:0]  value;
        for (n = 0; n < cut; n++)
            send_beat(8'($urandom), n == 0);
        for (off = 0; off < 512; off++)
        begin
            value = 8'($urandom);
            rel   = 9'(off) - mbrp_pkg::TABLE_BASE;
            if (off >= mbrp_pkg::TABLE_BASE && off < mbrp_pkg::SIG_LOW_OFFSET)
            begin
                if (rel[3:0] == 4'd0)
                    value = ents[rel[5:4]].boot;
                else if (rel[3:0] == 4'd4)
                    value = ents[rel[5:4]].sys_type;
                else if (rel[3:2] == 2'b10)
                    value = ents[rel[5:4]].start[{rel[1:0], 3'b000} +: 8];
                else if (rel[3:2] == 2'b11)
                    value = ents[rel[5:4]].count[{rel[1:0], 3'b000} +: 8];
            end
            else if (off == mbrp_pkg::SIG_LOW_OFFSET)
            begin
                value = sig[7:0];
            end
            else if (off == mbrp_pkg::SIG_HIGH_OFFSET)
            begin
                value = sig[15:8];
            end
            send_beat(value, off == 0 && (mark || cut != 0));
        end
        frames_sent++;
    endtask

    // Stop offering bytes, wait for every pending result, then let the block go quiet.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (slot_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges.
    task automatic configure(logic [31:0] blocks, logic [7:0] code_a, logic [7:0] code_b);
        cfg_we    <= 1'b1;
        cfg_index <= mbrp_pkg::CFG_DISK_BLOCKS;
        cfg_wdata <= blocks;
        @(posedge clk);
        cfg_disk_blocks = blocks;
        cfg_index <= mbrp_pkg::CFG_UNIX_PRIMARY;
        cfg_wdata <= {24'd0, code_a};
        @(posedge clk);
        cfg_unix_a = code_a;
        cfg_index <= mbrp_pkg::CFG_UNIX_SECONDARY;
        cfg_wdata <= {24'd0, code_b};
        @(posedge clk);
        cfg_unix_b = code_b;
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Compare each taken result beat with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        mbrp_pkg::out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (slot_results_due.size() == 0)
            begin
                error_count++;
                $display("%0t: result for slot %0d arrived with nothing expected",
                         $time, out_data.slot_number);
            end
            else
            begin
                want = slot_results_due.pop_front();
                results_checked++;
                check_field("slot_number", 32'(want.slot_number),
                            32'(out_data.slot_number));
                check_field("entry_valid", 32'(want.entry_valid),
                            32'(out_data.entry_valid));
                check_field("system_type", 32'(want.system_type),
                            32'(out_data.system_type));
                check_field("start_block", 32'(want.start_block),
                            32'(out_data.start_block));
                check_field("block_count", 32'(want.block_count),
                            32'(out_data.block_count));
                check_field("table_present", 32'(want.table_present),
                            32'(out_data.table_present));
                check_field("unix_slot", 32'(want.unix_slot), 32'(out_data.unix_slot));
                check_field("label_read_needed", 32'(want.label_read_needed),
                            32'(out_data.label_read_needed));
                check_field("last_of_run", 32'(want.last_of_run),
                            32'(out_data.last_of_run));
            end
        end
    end

    // Receiver: random stall runs, plus one long hold-off on request.
    initial
    begin : receiver
        int unsigned run_left;
        out_stall = 1'b0;
        run_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                run_left = 0;
            end
            else if (run_left != 0)
            begin
                run_left--;
            end
            else if ($urandom_range(0, 99) < 30)
            begin
                out_stall <= 1'b1;
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b0;
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                       : $urandom_range(0, 12);
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, quiet);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        sector_row_t row;
        part_table_t ents;
        logic [15:0] sig;
        logic        mark;
        int unsigned cut;
        int          g;
        int          f;
        int          s;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = mbrp_pkg::CFG_DISK_BLOCKS;
        cfg_wdata = '0;

        // Directed sectors. Fields: reconfig, disk, codes, entries, signature, wrap,
        // cut, typed, then the typed expectation (valid per slot, present, unix, label).
        // Reset settings: a zero-block disk rejects every entry.
        sector_rows[0] = '{1'b0, 32'd0, 8'd0, 8'd0,
            '{part_entry(mbrp_pkg::ACTIVE, mbrp_pkg::SUNIXOS, 0, 10),
              part_entry(8'h00, mbrp_pkg::SUNIXOS2, 20, 5),
              part_entry(8'h00, 8'h07, 0, 1), part_entry(8'h00, 8'h00, 0, 0)},
            mbrp_pkg::BOOT_SIGNATURE, 1'b0, 9'd0, 1'b1, 4'b0000, 1'b1, 3'd0, 1'b0};
        // Byte-swapped signature, sent through the offset wrap with no restart mark.
        sector_rows[1] = sector_rows[0];
        sector_rows[1].sig = 16'h55AA;
        sector_rows[1].wrap = 1'b1;
        sector_rows[1].want_present = 1'b0;
        sector_rows[1].want_label = 1'b1;
        // Largest disk: field extremes, negative count, active unix entry taking over.
        sector_rows[2] = '{1'b1, 32'hFFFF_FFFF, mbrp_pkg::SUNIXOS, mbrp_pkg::SUNIXOS2,
            '{part_entry(mbrp_pkg::ACTIVE, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000),
              part_entry(8'h00, mbrp_pkg::SUNIXOS, 0, 32'h7FFF_FFFF),
              part_entry(mbrp_pkg::ACTIVE, mbrp_pkg::SUNIXOS2, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF),
              part_entry(8'h00, 8'h00, 1, 1)},
            mbrp_pkg::BOOT_SIGNATURE, 1'b0, 9'd0, 1'b1, 4'b0110, 1'b1, 3'd3, 1'b1};
        // Negative start, zero count; an inactive later unix entry does not take over.
        sector_rows[3] = '{1'b0, 32'd0, 8'd0, 8'd0,
            '{part_entry(8'h00, 8'h01, 32'h8000_0000, 1),
              part_entry(mbrp_pkg::ACTIVE, mbrp_pkg::SUNIXOS, 0, 0),
              part_entry(8'h00, mbrp_pkg::SUNIXOS2, 5, 5),
              part_entry(8'h7F, mbrp_pkg::SUNIXOS, 0, 1)},
            mbrp_pkg::BOOT_SIGNATURE, 1'b0, 9'd0, 1'b1, 4'b1100, 1'b1, 3'd3, 1'b1};
        // Wrong signature high byte.
        sector_rows[4] = sector_rows[2];
        sector_rows[4].reconfig = 1'b0;
        sector_rows[4].sig = 16'hAB55;
        sector_rows[4].want_valid = 4'b0000;
        sector_rows[4].want_present = 1'b0;
        sector_rows[4].want_unix = 3'd0;
        // Wrong signature low byte, after a frame cut off in the middle of the table.
        sector_rows[5] = sector_rows[4];
        sector_rows[5].sig = 16'hAA54;
        sector_rows[5].cut = 9'd470;
        // Small disk: exact fit, one block past the end, other unix codes.
        sector_rows[6] = '{1'b1, 32'd1000, 8'h07, 8'h0C,
            '{part_entry(8'h00, 8'h07, 0, 1000), part_entry(8'h00, 8'h0C, 1, 1000),
              part_entry(mbrp_pkg::ACTIVE, 8'h0C, 999, 1),
              part_entry(8'h00, 8'h83, 10, 10)},
            mbrp_pkg::BOOT_SIGNATURE, 1'b0, 9'd0, 1'b1, 4'b1101, 1'b1, 3'd3, 1'b1};
        sector_rows[7] = '{1'b0, 32'd0, 8'd0, 8'd0,
            '{part_entry(mbrp_pkg::ACTIVE, 8'h07, 0, 100),
              part_entry(8'h00, 8'h0C, 100, 100),
              part_entry(8'h00, 8'h05, 200, 800),
              part_entry(mbrp_pkg::ACTIVE, 8'h83, 0, 1000)},
            mbrp_pkg::BOOT_SIGNATURE, 1'b0, 9'd0, 1'b0, 4'b0000, 1'b0, 3'd0, 1'b0};
        // No unix entry at all, so no label read; sent through the wrap again.
        sector_rows[8] = '{1'b0, 32'd0, 8'd0, 8'd0,
            '{part_entry(8'h00, 8'h83, 0, 500), part_entry(8'h00, 8'h05, 500, 500),
              part_entry(8'h00, 8'h00, 0, 0),
              part_entry(8'h00, 8'hEE, 32'hFFFF_FFFF, 32'hFFFF_FFFF)},
            mbrp_pkg::BOOT_SIGNATURE, 1'b1, 9'd0, 1'b0, 4'b0000, 1'b0, 3'd0, 1'b0};
        // Code register extremes: a zero type never counts even when it is a unix code.
        sector_rows[9] = '{1'b1, 32'hFFFF_FFFF, 8'hFF, 8'h00,
            '{part_entry(8'h00, 8'h00, 0, 1), part_entry(8'h00, 8'hFF, 0, 1),
              part_entry(mbrp_pkg::ACTIVE, 8'hFF, 1, 1),
              part_entry(8'hFF, 8'hAA, 32'hFFFF_FFFE, 1)},
            mbrp_pkg::BOOT_SIGNATURE, 1'b0, 9'd0, 1'b1, 4'b0110, 1'b1, 3'd3, 1'b1};
        // Every slot an active unix entry on a tiny disk, after a restart outside the table.
        sector_rows[10] = '{1'b1, 32'd5, mbrp_pkg::SUNIXOS, mbrp_pkg::SUNIXOS2,
            '{part_entry(mbrp_pkg::ACTIVE, mbrp_pkg::SUNIXOS, 0, 1),
              part_entry(mbrp_pkg::ACTIVE, mbrp_pkg::SUNIXOS2, 1, 1),
              part_entry(mbrp_pkg::ACTIVE, mbrp_pkg::SUNIXOS, 2, 1),
              part_entry(mbrp_pkg::ACTIVE, mbrp_pkg::SUNIXOS2, 3, 2)},
            mbrp_pkg::BOOT_SIGNATURE, 1'b0, 9'd200, 1'b0, 4'b0000, 1'b0, 3'd0, 1'b0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part.
        foreach (sector_rows[r])
        begin
            row = sector_rows[r];
            if (row.reconfig)
            begin
                drain_results();
                configure(row.disk, row.code_a, row.code_b);
            end
            if (row.typed)
            begin
                for (s = 0; s < mbrp_pkg::NUM_SLOTS; s++)
                begin
                    typed_beats[s] = '0;
                    typed_beats[s].slot_number   = 3'(s + 1);
                    typed_beats[s].table_present = row.want_present;
                    if (row.want_valid[s])
                    begin
                        typed_beats[s].entry_valid = 1'b1;
                        typed_beats[s].system_type = row.ents[s].sys_type;
                        typed_beats[s].start_block = row.ents[s].start[30:0];
                        typed_beats[s].block_count = row.ents[s].count[30:0];
                    end
                end
                typed_beats[mbrp_pkg::NUM_SLOTS-1].unix_slot         = row.want_unix;
                typed_beats[mbrp_pkg::NUM_SLOTS-1].label_read_needed = row.want_label;
                typed_beats[mbrp_pkg::NUM_SLOTS-1].last_of_run       = 1'b1;
                typed_pending = 1'b1;
            end
            send_sector(row.ents, row.sig, !row.wrap, 32'(row.cut));
        end

        // Random part: three register settings, mostly well-formed sectors with
        // random tables, some broken frames and bad signatures.
        for (g = 0; g < 3; g++)
        begin
            drain_results();
            case (g)
                0:       configure($urandom_range(1, 5000), mbrp_pkg::SUNIXOS,
                                   mbrp_pkg::SUNIXOS2);
                1:       configure($urandom, 8'($urandom), 8'($urandom));
                default: configure(32'hFFFF_FFFF, 8'($urandom), mbrp_pkg::SUNIXOS);
            endcase
            for (f = 0; f < FRAMES_PER_GROUP; f++)
            begin
                // Long receiver hold-off while bytes keep coming.
                if (g == 0 && f == 2)
                    hold_off_request = 1'b1;
                // Sender pause until every result is out.
                if (g == 1 && f == 3)
                    drain_results();
                calm_in = ($urandom_range(0, 3) == 0);
                for (s = 0; s < mbrp_pkg::NUM_SLOTS; s++)
                    ents[s] = random_entry();
                case ($urandom_range(0, 9))
                    0:       sig = {8'hAA, 8'($urandom)};
                    1:       sig = {8'($urandom), 8'h55};
                    2:       sig = 16'($urandom);
                    default: sig = mbrp_pkg::BOOT_SIGNATURE;
                endcase
                cut  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 511) : 0;
                mark = !(pred_offset == 9'd0 && $urandom_range(0, 4) == 0);
                send_sector(ents, sig, mark, cut);
            end
        end
        calm_in = 1'b0;
        drain_results();

        $display("Run covered %0d sectors (%0d bytes) under eight register settings,",
                 frames_sent, bytes_taken);
        $display("with %0d slot results checked and %0d errors.", results_checked,
                 error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mbrp_pkg.sv
rtl/mbrp_entry_store.sv
rtl/mbrp_slot_check.sv
rtl/mbr_partition_table_parser_unit.sv
sim/testbench.sv
